/* src/htb_pkg.sv */
`timescale 1ns / 1ps
// Shared types and codes for the Huffman tree build and decode block.
// No dependencies; every other file imports this package.
package htb_pkg;

	localparam int COUNT_W  = 31;
	localparam int WEIGHT_W = 39;
	localparam int NODE_AW  = 9;
	localparam int NODE_DEPTH = 512;

	localparam logic [NODE_AW-1:0] NO_CHILD = 9'h1FF;

	localparam logic [1:0] OP_LOAD   = 2'd0;
	localparam logic [1:0] OP_BUILD  = 2'd1;
	localparam logic [1:0] OP_DECODE = 2'd2;

	localparam logic [1:0] ST_SYM    = 2'd0;
	localparam logic [1:0] ST_BUILT  = 2'd1;
	localparam logic [1:0] ST_EMPTY  = 2'd2;
	localparam logic [1:0] ST_BADBIT = 2'd3;

	localparam logic [3:0] MAX_BITS = 4'd8;

	typedef struct packed {
		logic [7:0]         sym;
		logic [NODE_AW-1:0] right;
		logic [NODE_AW-1:0] left;
	} link_t;

	typedef struct packed {
		logic [NODE_AW-1:0]  node;
		logic [WEIGHT_W-1:0] weight;
	} ord_ent_t;

	typedef struct packed {
		logic [1:0]         op;
		logic [7:0]         idx;
		logic [COUNT_W-1:0] cnt;
		logic [7:0]         code;
		logic [3:0]         bits;
	} item_t;

	typedef struct packed {
		logic  valid;
		item_t item;
	} qhead_t;

	typedef struct packed {
		logic [7:0] sym;
		logic [1:0] status;
	} res_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_B_RD,
		S_B_CHK,
		S_B_NXT,
		S_B_AFT,
		S_B_ONE,
		S_M_A,
		S_M_B,
		S_M_MRG,
		S_I_RD,
		S_I_CHK,
		S_R_CAP,
		S_R_LNK,
		S_D_BIT,
		S_D_LNK,
		S_FIN
	} back_state_t;

endpackage

/* src/htb_front.sv */
`timescale 1ns / 1ps
// Front end: takes input words, drops ones with no effect, clamps the bit
// count and holds them in a two-entry queue for the back end. Uses htb_pkg.
module htb_front import htb_pkg::*; #(
	parameter int SYMBOL_COUNT = 256
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  logic [1:0]   op,
	input  logic [7:0]   symbol_index,
	input  logic [30:0]  count_value,
	input  logic [7:0]   code_byte,
	input  logic [3:0]   valid_bits,
	output qhead_t       qh,
	input  logic         q_pop
);

	item_t      buf_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       keep, push;
	item_t      new_item;

	assign in_ready = (cnt_q != 2'd2);

	always_comb begin
		keep = (op == OP_BUILD) || (op == OP_DECODE) ||
		       ((op == OP_LOAD) && ({1'b0, symbol_index} < 9'(SYMBOL_COUNT)));
		new_item.op   = op;
		new_item.idx  = symbol_index;
		new_item.cnt  = count_value;
		new_item.code = code_byte;
		new_item.bits = (valid_bits > MAX_BITS) ? MAX_BITS : valid_bits;
	end

	assign push = in_valid && in_ready && keep;

	always_ff @(posedge clk) begin
		if (push)
			buf_q[wp_q] <= new_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wp_q <= ~wp_q;
			if (q_pop)
				rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end

	assign qh.valid = (cnt_q != 2'd0);
	assign qh.item  = buf_q[rp_q];

endmodule

/* src/htb_back.sv */
`timescale 1ns / 1ps
// Back end: count store, tree build sequencer, bit walker and result register.
// Uses htb_pkg; fed by htb_front through its queue head.
module htb_back import htb_pkg::*; #(
	parameter int SYMBOL_COUNT = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	input  qhead_t     qh,
	output logic       q_pop,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] symbol,
	output logic [1:0] status,
	output logic       last
);

	localparam int IW = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
	localparam int CW = $clog2(SYMBOL_COUNT + 1);

	back_state_t state_q, state_d;

	// memories
	logic [COUNT_W-1:0] cmem [SYMBOL_COUNT];
	ord_ent_t           omem [NODE_DEPTH];
	link_t              lmem [NODE_DEPTH];
	logic [COUNT_W-1:0] cdata;
	ord_ent_t           odata;
	link_t              ldata;
	logic [SYMBOL_COUNT-1:0] cvalid_q;

	logic [CW-1:0]       i_q;
	logic [NODE_AW-1:0]  n_q, head_q, len_q, k_q, ins_node_q;
	logic [WEIGHT_W-1:0] ins_w_q;
	ord_ent_t            a_q;
	logic                ret_q, ready_q;
	link_t               root_link_q, link_q;
	logic [3:0]          bits_q;
	logic [7:0]          byte_q;
	logic                pend_v_q, out_v_q, out_last_q;
	res_t                pend_q, out_q;

	// control
	logic                c_we, c_ren, o_ren, o_we, l_ren, l_we;
	logic [NODE_AW-1:0]  o_raddr, o_waddr, l_raddr, l_waddr;
	ord_ent_t            o_wdata;
	link_t               l_wdata;
	logic                emit_v, stall, out_free, fin_push, pend_push, push;
	res_t                emit_r;
	logic [COUNT_W-1:0]  w_cur;
	logic [NODE_AW-1:0]  child;
	logic                leaf, a_lighter;
	logic [WEIGHT_W-1:0] w_sum;

	assign out_free  = !out_v_q || out_ready;
	assign w_cur     = cvalid_q[i_q[IW-1:0]] ? cdata : '0;
	assign child     = byte_q[7] ? link_q.right : link_q.left;
	assign leaf      = (ldata.left == NO_CHILD) && (ldata.right == NO_CHILD);
	assign a_lighter = a_q.weight < odata.weight;
	assign w_sum     = a_q.weight + odata.weight;

	// datapath control
	always_comb begin
		c_we = 1'b0; c_ren = 1'b0; o_ren = 1'b0; o_we = 1'b0;
		l_ren = 1'b0; l_we = 1'b0;
		o_raddr = head_q; o_waddr = head_q + k_q; o_wdata = '0;
		l_raddr = child; l_waddr = n_q; l_wdata = '0;
		emit_v = 1'b0; emit_r = '0; q_pop = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				q_pop = qh.valid;
				c_we  = qh.valid && (qh.item.op == OP_LOAD);
			end
			S_B_RD: c_ren = 1'b1;
			S_B_CHK: begin
				l_we    = (w_cur != '0);
				l_wdata = '{sym: 8'(i_q), right: NO_CHILD, left: NO_CHILD};
			end
			S_B_AFT: o_ren = (len_q == 9'd1);
			S_B_ONE: begin
				l_we    = 1'b1;
				l_wdata = '{sym: 8'd0, right: NO_CHILD, left: odata.node};
			end
			S_M_A: o_ren = 1'b1;
			S_M_B: begin
				o_ren   = 1'b1;
				o_raddr = head_q + 9'd1;
			end
			S_M_MRG: begin
				l_we    = 1'b1;
				l_wdata = a_lighter ?
					'{sym: 8'd0, right: odata.node, left: a_q.node} :
					'{sym: 8'd0, right: a_q.node, left: odata.node};
			end
			S_I_RD: begin
				o_ren   = (k_q != '0);
				o_raddr = head_q + k_q - 9'd1;
				o_we    = (k_q == '0);
				o_wdata = '{node: ins_node_q, weight: ins_w_q};
			end
			S_I_CHK: begin
				o_we    = 1'b1;
				o_wdata = (odata.weight >= ins_w_q) ? odata :
					'{node: ins_node_q, weight: ins_w_q};
			end
			S_R_CAP: begin
				l_ren   = 1'b1;
				l_raddr = odata.node;
			end
			S_R_LNK: ;
			S_D_BIT: begin
				emit_v = (child == NO_CHILD);
				emit_r = '{sym: 8'd0, status: ST_BADBIT};
				l_ren  = (child != NO_CHILD) && !stall;
			end
			S_D_LNK: begin
				emit_v = leaf;
				emit_r = '{sym: ldata.sym, status: ST_SYM};
			end
			S_FIN: ;
			default: ;
		endcase
	end

	assign stall     = emit_v && pend_v_q && !out_free;
	assign pend_push = emit_v && pend_v_q && !stall;
	assign fin_push  = (state_q == S_FIN) && pend_v_q && out_free;
	assign push      = pend_push || fin_push;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (qh.valid) begin
					if (qh.item.op == OP_BUILD)
						state_d = S_B_RD;
					else if (qh.item.op == OP_DECODE) begin
						if (!ready_q)
							state_d = S_FIN;
						else if (qh.item.bits != '0)
							state_d = S_D_BIT;
					end
				end
			end
			S_B_RD:  state_d = S_B_CHK;
			S_B_CHK: state_d = (w_cur != '0) ? S_I_RD : S_B_NXT;
			S_B_NXT: state_d = (i_q == CW'(SYMBOL_COUNT)) ? S_B_AFT : S_B_RD;
			S_B_AFT: begin
				if (len_q == '0)
					state_d = S_FIN;
				else if (len_q == 9'd1)
					state_d = S_B_ONE;
				else
					state_d = S_M_A;
			end
			S_B_ONE: state_d = S_I_RD;
			S_M_A:   state_d = (len_q > 9'd1) ? S_M_B : S_R_CAP;
			S_M_B:   state_d = S_M_MRG;
			S_M_MRG: state_d = S_I_RD;
			S_I_RD: begin
				if (k_q != '0)
					state_d = S_I_CHK;
				else
					state_d = ret_q ? S_M_A : S_B_NXT;
			end
			S_I_CHK: begin
				if (odata.weight >= ins_w_q)
					state_d = S_I_RD;
				else
					state_d = ret_q ? S_M_A : S_B_NXT;
			end
			S_R_CAP: state_d = S_R_LNK;
			S_R_LNK: state_d = S_FIN;
			S_D_BIT: begin
				if (!stall) begin
					if (child != NO_CHILD)
						state_d = S_D_LNK;
					else if (bits_q == 4'd1)
						state_d = S_FIN;
				end
			end
			S_D_LNK: begin
				if (!stall)
					state_d = (bits_q == '0) ? S_FIN : S_D_BIT;
			end
			S_FIN: begin
				if (!pend_v_q || out_free)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// memories: registered reads, no reset
	always_ff @(posedge clk) begin
		if (c_we)
			cmem[qh.item.idx[IW-1:0]] <= qh.item.cnt;
		if (c_ren)
			cdata <= cmem[i_q[IW-1:0]];
		if (o_we)
			omem[o_waddr] <= o_wdata;
		if (o_ren)
			odata <= omem[o_raddr];
		if (l_we)
			lmem[l_waddr] <= l_wdata;
		if (l_ren)
			ldata <= lmem[l_raddr];
	end

	// payload registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				bits_q <= qh.item.bits;
				byte_q <= qh.item.code;
				i_q    <= '0;
			end
			S_B_CHK: begin
				i_q        <= i_q + 1'b1;
				k_q        <= len_q;
				ins_node_q <= n_q;
				ins_w_q    <= WEIGHT_W'(w_cur);
				ret_q      <= 1'b0;
			end
			S_B_ONE: begin
				k_q        <= '0;
				ins_node_q <= n_q;
				ins_w_q    <= odata.weight;
				ret_q      <= 1'b1;
			end
			S_M_B: a_q <= odata;
			S_M_MRG: begin
				k_q        <= len_q - 9'd2;
				ins_node_q <= n_q;
				ins_w_q    <= w_sum;
				ret_q      <= 1'b1;
			end
			S_I_CHK: begin
				if (odata.weight >= ins_w_q)
					k_q <= k_q - 9'd1;
			end
			S_R_LNK: begin
				root_link_q <= ldata;
				link_q      <= ldata;
			end
			S_D_BIT: begin
				if (!stall) begin
					byte_q <= {byte_q[6:0], 1'b0};
					bits_q <= bits_q - 4'd1;
					if (child == NO_CHILD)
						link_q <= root_link_q;
				end
			end
			S_D_LNK: begin
				if (!stall)
					link_q <= leaf ? root_link_q : ldata;
			end
			default: ;
		endcase
		if (push)
			out_q <= pend_q;
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cvalid_q   <= '0;
			ready_q    <= 1'b0;
			n_q        <= '0;
			head_q     <= '0;
			len_q      <= '0;
			pend_v_q   <= 1'b0;
			pend_q     <= '0;
			out_v_q    <= 1'b0;
			out_last_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (c_we)
				cvalid_q[qh.item.idx[IW-1:0]] <= 1'b1;
			unique case (state_q)
				S_IDLE: begin
					n_q    <= '0;
					head_q <= '0;
					len_q  <= '0;
					if (qh.valid && (qh.item.op == OP_DECODE) && !ready_q) begin
						pend_v_q <= 1'b1;
						pend_q   <= '{sym: 8'd0, status: ST_EMPTY};
					end
				end
				S_B_CHK: begin
					if (w_cur != '0)
						n_q <= n_q + 9'd1;
				end
				S_B_AFT: begin
					if (len_q == '0) begin
						ready_q  <= 1'b0;
						pend_v_q <= 1'b1;
						pend_q   <= '{sym: 8'd0, status: ST_EMPTY};
					end
				end
				S_B_ONE: begin
					n_q    <= n_q + 9'd1;
					head_q <= head_q + 9'd1;
					len_q  <= len_q - 9'd1;
				end
				S_M_MRG: begin
					n_q    <= n_q + 9'd1;
					head_q <= head_q + 9'd2;
					len_q  <= len_q - 9'd2;
				end
				S_I_RD: begin
					if (k_q == '0)
						len_q <= len_q + 9'd1;
				end
				S_I_CHK: begin
					if (odata.weight < ins_w_q)
						len_q <= len_q + 9'd1;
				end
				S_R_LNK: begin
					ready_q  <= 1'b1;
					pend_v_q <= 1'b1;
					pend_q   <= '{sym: 8'd0, status: ST_BUILT};
				end
				S_D_BIT, S_D_LNK: begin
					if (emit_v && !stall) begin
						pend_v_q <= 1'b1;
						pend_q   <= emit_r;
					end
				end
				S_FIN: begin
					if (fin_push)
						pend_v_q <= 1'b0;
				end
				default: ;
			endcase
			if (push) begin
				out_v_q    <= 1'b1;
				out_last_q <= fin_push;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_v_q;
	assign symbol    = out_q.sym;
	assign status    = out_q.status;
	assign last      = out_last_q;

endmodule

/* src/huffman_tree_build_decode.sv */
`timescale 1ns / 1ps
// Huffman tree build and decode. Decode walks the code bits of a byte one at a time, with
// an extra state when a bit leads to a child link read, plus queue, pop, finish and
// output register. One word at a time in the back.
// Build: scans every symbol, adds each nonzero count to a list by sorted insert, shifting
// entries as it goes, then merges the two lightest entries until one is left.
// arst_n clears control state and the count valid bits; no clearing pass.
module huffman_tree_build_decode import htb_pkg::*; #(
	parameter int SYMBOL_COUNT = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  op,
	input  logic [7:0]  symbol_index,
	input  logic [30:0] count_value,
	input  logic [7:0]  code_byte,
	input  logic [3:0]  valid_bits,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  symbol,
	output logic [1:0]  status,
	output logic        last
);

	qhead_t qh;
	logic   q_pop;

	htb_front #(.SYMBOL_COUNT(SYMBOL_COUNT)) u_front (
		.clk, .arst_n, .in_valid, .in_ready, .op, .symbol_index,
		.count_value, .code_byte, .valid_bits, .qh, .q_pop
	);

	htb_back #(.SYMBOL_COUNT(SYMBOL_COUNT)) u_back (
		.clk, .arst_n, .qh, .q_pop, .out_valid, .out_ready,
		.symbol, .status, .last
	);

endmodule

/* src/htb_checker.sv */
`timescale 1ns / 1ps
// Port checker for huffman_tree_build_decode, bound to the top level.
// Uses htb_pkg status codes.
module htb_checker import htb_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] symbol,
	input logic [1:0] status,
	input logic       last
);

	// hold a stalled result word
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(symbol) &&
		$stable(status) && $stable(last))
		else $error("result word changed while stalled");

	a_sym_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ST_SYM) |-> symbol == 8'd0)
		else $error("non-symbol result carries a symbol");

	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ((status == ST_BUILT) || (status == ST_EMPTY)) |-> last)
		else $error("build or empty result not marked last");

endmodule

bind huffman_tree_build_decode htb_checker u_chk (.*);
